// ----- rtl/fmr_pkg.sv -----
// Shared types and constants for the framed message receiver.
package fmr_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned TYPE_W     = 16;
   localparam int unsigned LEN_W      = 6;
   localparam int unsigned INDEX_W    = 5;
   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [BYTE_W-1:0] BYTE_START = 8'h02;
   localparam logic [BYTE_W-1:0] BYTE_END   = 8'h03;
   localparam logic [BYTE_W-1:0] CHECK_SEED = 8'hAA;

   localparam logic [CSR_INDEX_W-1:0] REG_OWN_ADDRESS = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TYPE_COUNT  = 4'd1;

   localparam logic [BYTE_W-1:0] OWN_ADDRESS_RESET = 8'd0;
   localparam logic [TYPE_W-1:0] TYPE_COUNT_RESET  = 16'd16;

   // Header of one accepted frame, handed from front to back.
   typedef struct packed {
      logic [TYPE_W-1:0] msg_type;
      logic [BYTE_W-1:0] source;
      logic [BYTE_W-1:0] destination;
      logic [LEN_W-1:0]  length;
   } frame_desc_type;

   // Status of the frame queue.
   typedef struct packed {
      logic full;
      logic empty;
      logic wr_ptr;
      logic rd_ptr;
   } queue_status_type;

endpackage

// ----- rtl/fmr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fmr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/fmr_front.sv -----
// Front end: unstuffs link bytes, checks the frame and stores its data.
module fmr_front import fmr_pkg::*; #(
   parameter  int unsigned MAX_DATA = 32,
   localparam int unsigned IDX_W    = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [BYTE_W-1:0]        req_rx_byte,
   input  logic                     csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wr_data,
   input  logic                     wr_bank,
   output logic                     ram_wr_en,
   output logic [IDX_W:0]           ram_wr_addr,
   output logic [BYTE_W-1:0]        ram_wr_data,
   output logic                     push,
   output frame_desc_type           push_desc
);

   localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_DATA);

   typedef enum logic [3:0] {
      PH_WAIT, PH_TYPE_LO, PH_TYPE_HI, PH_SOURCE, PH_DEST,
      PH_LENGTH, PH_DATA, PH_CHECK, PH_CLOSE
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic              esc_ff, esc_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [BYTE_W-1:0] cks_ff, cks_in;
   logic [TYPE_W-1:0] type_ff, type_in;
   logic [BYTE_W-1:0] src_ff, src_in;
   logic [BYTE_W-1:0] dst_ff, dst_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [BYTE_W-1:0] own_ff;
   logic [TYPE_W-1:0] tcount_ff;

   logic              accept;
   logic              take;
   logic              abort;
   logic [BYTE_W-1:0] b;

   assign accept = req_valid & req_ready;
   assign b      = req_rx_byte;

   always_comb begin
      phase_in  = phase_ff;
      esc_in    = esc_ff;
      cnt_in    = cnt_ff;
      cks_in    = cks_ff;
      type_in   = type_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      len_in    = len_ff;
      take      = 1'b0;
      abort     = 1'b0;
      push      = 1'b0;
      ram_wr_en = 1'b0;

      if (accept) begin
         unique case (phase_ff)
            PH_WAIT: begin
               if (b == BYTE_START) phase_in = PH_TYPE_LO;
            end
            PH_CLOSE: begin
               // closing byte is never unstuffed
               if (b == BYTE_END) push = 1'b1;
               abort = 1'b1;
            end
            default: begin
               if (esc_ff) begin
                  if (b == BYTE_START) begin
                     esc_in = 1'b0;
                     take   = 1'b1;
                  end else begin
                     abort = 1'b1;
                  end
               end else if (b == BYTE_START) begin
                  esc_in = 1'b1;
               end else begin
                  take = 1'b1;
               end
            end
         endcase
      end

      if (take) begin
         unique case (phase_ff)
            PH_TYPE_LO: begin
               cks_in   = cks_ff ^ b;
               type_in  = {type_ff[TYPE_W-1:BYTE_W], b};
               phase_in = PH_TYPE_HI;
            end
            PH_TYPE_HI: begin
               cks_in  = cks_ff ^ b;
               type_in = {b, type_ff[BYTE_W-1:0]};
               if ({b, type_ff[BYTE_W-1:0]} < tcount_ff) phase_in = PH_SOURCE;
               else abort = 1'b1;
            end
            PH_SOURCE: begin
               cks_in   = cks_ff ^ b;
               src_in   = b;
               phase_in = PH_DEST;
            end
            PH_DEST: begin
               cks_in = cks_ff ^ b;
               dst_in = b;
               if (b == own_ff) phase_in = PH_LENGTH;
               else abort = 1'b1;
            end
            PH_LENGTH: begin
               cks_in = cks_ff ^ b;
               if (b == '0) begin
                  len_in   = '0;
                  phase_in = PH_CHECK;
               end else if (b <= MAX_LEN) begin
                  len_in   = b[LEN_W-1:0];
                  phase_in = PH_DATA;
               end else begin
                  abort = 1'b1;
               end
            end
            PH_DATA: begin
               cks_in    = cks_ff ^ b;
               ram_wr_en = 1'b1;
               cnt_in    = cnt_ff + LEN_W'(1);
               if (cnt_in >= len_ff) phase_in = PH_CHECK;
            end
            PH_CHECK: begin
               if (cks_ff == b) phase_in = PH_CLOSE;
               else abort = 1'b1;
            end
            default: abort = 1'b1;
         endcase
      end

      // drop a bad frame, or close a pushed one, and rearm the hunt for a start byte
      if (abort) begin
         phase_in = PH_WAIT;
         esc_in   = 1'b0;
         cnt_in   = '0;
         cks_in   = CHECK_SEED;
      end
   end

   assign ram_wr_addr = {wr_bank, cnt_ff[IDX_W-1:0]};
   assign ram_wr_data = b;

   assign push_desc.msg_type    = type_ff;
   assign push_desc.source      = src_ff;
   assign push_desc.destination = dst_ff;
   assign push_desc.length      = len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT;
         esc_ff    <= 1'b0;
         cnt_ff    <= '0;
         cks_ff    <= CHECK_SEED;
         type_ff   <= '0;
         src_ff    <= '0;
         dst_ff    <= '0;
         len_ff    <= '0;
         own_ff    <= OWN_ADDRESS_RESET;
         tcount_ff <= TYPE_COUNT_RESET;
      end else begin
         phase_ff <= phase_in;
         esc_ff   <= esc_in;
         cnt_ff   <= cnt_in;
         cks_ff   <= cks_in;
         type_ff  <= type_in;
         src_ff   <= src_in;
         dst_ff   <= dst_in;
         len_ff   <= len_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               REG_OWN_ADDRESS: own_ff    <= csr_wr_data[BYTE_W-1:0];
               REG_TYPE_COUNT:  tcount_ff <= csr_wr_data[TYPE_W-1:0];
               default: ;
            endcase
         end
      end
   end

endmodule

// ----- rtl/fmr_desc_queue.sv -----
// Two-entry queue of accepted frame headers; entry slot i owns data bank i.
module fmr_desc_queue import fmr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  frame_desc_type   push_desc,
   input  logic             pop,
   output frame_desc_type   head_desc,
   output queue_status_type status
);

   frame_desc_type desc_ff [2];
   logic           wr_ptr_ff;
   logic           rd_ptr_ff;
   logic [1:0]     count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      else if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) desc_ff[wr_ptr_ff] <= push_desc;
   end

   assign head_desc     = desc_ff[rd_ptr_ff];
   assign status.full   = (count_ff == 2'd2);
   assign status.empty  = (count_ff == 2'd0);
   assign status.wr_ptr = wr_ptr_ff;
   assign status.rd_ptr = rd_ptr_ff;

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("frame pushed into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("frame popped from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

endmodule

// ----- rtl/fmr_back.sv -----
// Back end: plays one queued frame out as a run of results, one per data byte, or a single one for an empty frame.
module fmr_back import fmr_pkg::*; #(
   parameter  int unsigned MAX_DATA = 32,
   localparam int unsigned IDX_W    = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  frame_desc_type      head_desc,
   input  queue_status_type    status,
   input  logic [BYTE_W-1:0]   ram_rd_data,
   output logic [IDX_W:0]      ram_rd_addr,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [TYPE_W-1:0]   rsp_msg_type,
   output logic [BYTE_W-1:0]   rsp_source,
   output logic [BYTE_W-1:0]   rsp_destination,
   output logic [LEN_W-1:0]    rsp_length,
   output logic [BYTE_W-1:0]   rsp_data_byte,
   output logic [INDEX_W-1:0]  rsp_data_index,
   output logic                rsp_last
);

   logic [LEN_W-1:0] k_ff, k_in;
   logic [LEN_W-1:0] n_results;
   logic             is_last;
   logic             fire;
   logic             rd_ptr_next;

   assign n_results = (head_desc.length == '0) ? LEN_W'(1) : head_desc.length;
   assign is_last   = ((k_ff + LEN_W'(1)) == n_results);
   assign rsp_valid = !status.empty;
   assign fire      = rsp_valid & rsp_ready;
   assign pop       = fire & is_last;

   always_comb begin
      k_in = k_ff;
      if (pop) k_in = '0;
      else if (fire) k_in = k_ff + LEN_W'(1);
   end

   // read ahead at the next index so the registered data lines up with k_ff
   assign rd_ptr_next = status.rd_ptr ^ pop;
   assign ram_rd_addr = {rd_ptr_next, k_in[IDX_W-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else begin
         k_ff <= k_in;
      end
   end

   assign rsp_msg_type    = head_desc.msg_type;
   assign rsp_source      = head_desc.source;
   assign rsp_destination = head_desc.destination;
   assign rsp_length      = head_desc.length;
   assign rsp_data_byte   = (head_desc.length == '0) ? '0 : ram_rd_data;
   assign rsp_data_index  = k_ff[INDEX_W-1:0];
   assign rsp_last        = is_last;

   a_index_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (k_ff < n_results))
      else $error("result index beyond frame length");

endmodule

// ----- rtl/framed_message_receiver.sv -----
// Top level of the framed message receiver.
//
// req_* carries raw link bytes (req_rx_byte), one item per accepted byte.
// Frames are 0x02, type lo, type hi, source, destination, length, data,
// XOR checksum (seed 0xAA), 0x03, with 0x02 doubled inside the frame.
// rsp_* carries the results of a good frame: one item per data byte, or one
// item with data_byte zero for an empty frame; rsp_last marks the final one.
// csr_* writes own_address (index 0) and type_count (index 1); no read-back.
//
// Throughput: one byte per cycle in, one result per cycle out while rsp_ready
// is high. The front stores data bytes into one of two RAM banks and hands
// each good frame's header to a two-entry queue; the back plays the queue
// head out of its bank. The first result of a frame is offered the cycle
// after its 0x03 is taken, unless an earlier frame is still being played out
// ahead of it. req_ready drops while two finished frames wait, so a stalled
// receiver holds the link side back once both banks are full.
// Reset (synchronous) empties the queue, rearms the start-byte hunt and
// restores own_address 0 and type_count 16; RAM contents are not cleared.
module framed_message_receiver import fmr_pkg::*; #(
   parameter int unsigned MAX_DATA = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [BYTE_W-1:0]        req_rx_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [TYPE_W-1:0]        rsp_msg_type,
   output logic [BYTE_W-1:0]        rsp_source,
   output logic [BYTE_W-1:0]        rsp_destination,
   output logic [LEN_W-1:0]         rsp_length,
   output logic [BYTE_W-1:0]        rsp_data_byte,
   output logic [INDEX_W-1:0]       rsp_data_index,
   output logic                     rsp_last,
   input  logic                     csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wr_data
);

   localparam int unsigned IDX_W = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
   localparam int unsigned RAM_DEPTH = 2 * (2 ** IDX_W);

   logic              ram_wr_en;
   logic [IDX_W:0]    ram_wr_addr;
   logic [BYTE_W-1:0] ram_wr_data;
   logic [IDX_W:0]    ram_rd_addr;
   logic [BYTE_W-1:0] ram_rd_data;
   logic              push;
   logic              pop;
   frame_desc_type    push_desc;
   frame_desc_type    head_desc;
   queue_status_type  status;

   assign req_ready = !status.full;

   fmr_front #(.MAX_DATA(MAX_DATA)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .wr_bank     (status.wr_ptr),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .push        (push),
      .push_desc   (push_desc)
   );

   fmr_ram #(.WIDTH(BYTE_W), .DEPTH(RAM_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   fmr_desc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .status    (status)
   );

   fmr_back #(.MAX_DATA(MAX_DATA)) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_desc       (head_desc),
      .status          (status),
      .ram_rd_data     (ram_rd_data),
      .ram_rd_addr     (ram_rd_addr),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_msg_type    (rsp_msg_type),
      .rsp_source      (rsp_source),
      .rsp_destination (rsp_destination),
      .rsp_length      (rsp_length),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_data_index  (rsp_data_index),
      .rsp_last        (rsp_last)
   );

   a_bank_apart: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && !status.empty) |-> (status.wr_ptr != status.rd_ptr))
      else $error("data write into the bank being played out");

endmodule
